// ----- design/assert_macros.svh -----
// Assertion macros shared by the collision search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMPLIES(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(name, pre, post)
`define ASSERT_NEXT(name, pre, post)

`endif

`endif

// ----- design/hcs_pkg.sv -----
// Types, constants and hash helper functions for the collision search block.
package hcs_pkg;

  // Field widths.
  localparam int CHAR_W     = 7;
  localparam int MAX_CHARS  = 7;
  localparam int PREFIX_W   = CHAR_W * MAX_CHARS;
  localparam int SUFFIX_W   = 3 * CHAR_W;
  localparam int HASH_W     = 32;
  localparam int SLOTOUT_W  = 16;
  localparam int PLEN_W     = 3;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Hash constants.
  localparam logic [HASH_W-1:0] INV_1025 = 32'd3222273025;
  localparam logic [CHAR_W-1:0] CHAR_LO   = 7'd32;
  localparam logic [CHAR_W-1:0] CHAR_LAST = 7'd126;
  localparam int SHL_AMT = 10;
  localparam int SHR_AMT = 6;

  // Register reset values.
  localparam logic [PLEN_W-1:0]  PLEN_RESET  = 3'd7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1;

  // Request queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_TEST    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_LOADED    = 3'd0,
    ST_NO_MATCH  = 3'd1,
    ST_MATCH     = 3'd2,
    ST_LIMIT     = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_HASH   = 2'd0,
    CFG_PREFIX_LENGTH = 2'd1,
    CFG_MATCH_LIMIT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UNXOR,
    BK_UNSUB,
    BK_HASH,
    BK_READ,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [CHAR_W-1:0] suffix_char0;
    logic [CHAR_W-1:0] suffix_char1;
    logic [CHAR_W-1:0] suffix_char2;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [PREFIX_W-1:0]  prefix_text;
    logic [SUFFIX_W-1:0]  suffix_text;
    logic [HASH_W-1:0]    work_hash;
    logic [SLOTOUT_W-1:0] table_slot;
  } out_item_t;

  typedef struct packed {
    logic [HASH_W-1:0]  target_hash;
    logic [PLEN_W-1:0]  prefix_length;
    logic [LIMIT_W-1:0] match_limit;
  } cfg_t;

  // Classified request as held in the queue.
  typedef struct packed {
    cmd_e                kind;
    logic [SUFFIX_W-1:0] suffix;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

  // One table entry.
  typedef struct packed {
    logic                valid;
    logic [SUFFIX_W-1:0] suffix;
    logic [HASH_W-1:0]   hash;
  } entry_t;

  // Inverse of h ^= h >> 6 in closed form.
  function automatic logic [HASH_W-1:0] unxor(input logic [HASH_W-1:0] y);
    logic [HASH_W-1:0] x;
    x = y;
    for (int k = 1; k < 6; k++) begin
      x = x ^ (y >> (SHR_AMT * k));
    end
    return x;
  endfunction

  // One forward character step of the hash.
  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic [CHAR_W-1:0] c);
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
    a = h + HASH_W'(c);
    b = a + (a << SHL_AMT);
    return b ^ (b >> SHR_AMT);
  endfunction

endpackage

// ----- design/hcs_front.sv -----
// Request front end: classifies commands and queues them for the back end.
module hcs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hcs_pkg::in_item_t    in_data_i,
  input  hcs_pkg::back_status_t status_i,
  output hcs_pkg::head_t       head_o
);
  import hcs_pkg::*;

  localparam int CNT_W = PTR_W + 1;

  queue_item_t      q_mem [QUEUE_DEPTH];
  queue_item_t      item;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             full;
  logic             push;

  // Classify the incoming request; any code with the upper bit set restarts.
  always_comb begin
    item.suffix = {in_data_i.suffix_char2, in_data_i.suffix_char1, in_data_i.suffix_char0};
    unique case (in_data_i.command)
      CMD_LOAD: item.kind = CMD_LOAD;
      CMD_TEST: item.kind = CMD_TEST;
      default:  item.kind = CMD_RESTART;
    endcase
  end

  // Queue control.
  assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign in_stall_o = full || status_i.clearing;
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    wr_ptr_d = push       ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = status_i.pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CNT_W'(push) - CNT_W'(status_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = q_mem[rd_ptr_q];

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_no_push_full, push, count_q != CNT_W'(QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_no_pop_empty, status_i.pop, count_q != '0)
  `ASSERT_IMPLIES(a_stall_clearing, status_i.clearing, in_stall_o)

endmodule

// ----- design/hcs_back.sv -----
// Execution back end: table clearing, suffix unwinding, prefix hashing and lookup.
module hcs_back #(
  parameter int TABLE_DEPTH = 65536,
  parameter int MAX_PREFIX  = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hcs_pkg::cfg_t         cfg_i,
  input  hcs_pkg::head_t        head_i,
  output hcs_pkg::back_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output hcs_pkg::out_item_t    out_data_o
);
  import hcs_pkg::*;

  localparam int               SLOT_W  = $clog2(TABLE_DEPTH);
  localparam logic [PLEN_W-1:0] MAX_LEN = PLEN_W'(MAX_PREFIX);

  back_state_e                       state_q, state_d;
  logic [SLOT_W-1:0]                 clr_idx_q, clr_idx_d;
  queue_item_t                       item_q, item_d;
  logic                              skip_q, skip_d;
  status_e                           skip_st_q, skip_st_d;
  logic [HASH_W-1:0]                 h_q, h_d;
  logic [HASH_W-1:0]                 prod_q, prod_d;
  logic [1:0]                        ch_idx_q, ch_idx_d;
  logic [PLEN_W-1:0]                 rem_q, rem_d;
  logic [PLEN_W-1:0]                 len_q, len_d;
  logic [PREFIX_W-1:0]               work_q, work_d;
  logic [MAX_PREFIX-1:0][CHAR_W-1:0] prefix_q, prefix_d;
  logic [LIMIT_W-1:0]                matches_q, matches_d;
  logic                              exhausted_q, exhausted_d;

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_q;
  entry_t            mem_wdata;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_addr;

  out_item_t out_q;
  out_item_t res;
  logic      out_valid_q;
  logic      emit;
  logic      pop;

  logic                              hit;
  logic [MAX_PREFIX-1:0][CHAR_W-1:0] adv;
  logic                              adv_carry;
  logic [PREFIX_W-1:0]               ptext;
  logic [PLEN_W-1:0]                 used_len;
  logic [CHAR_W-1:0]                 cur_char;
  logic [HASH_W-1:0]                 slot_full;
  logic [SLOTOUT_W-1:0]              slot16;

  // Effective prefix length, clamped to 1..MAX_PREFIX.
  always_comb begin
    if (cfg_i.prefix_length == '0) begin
      used_len = PLEN_W'(1);
    end else if (cfg_i.prefix_length > MAX_LEN) begin
      used_len = MAX_LEN;
    end else begin
      used_len = cfg_i.prefix_length;
    end
  end

  // Suffix character being undone, last character first.
  always_comb begin
    unique case (ch_idx_q)
      2'd2:    cur_char = item_q.suffix[3*CHAR_W-1:2*CHAR_W];
      2'd1:    cur_char = item_q.suffix[2*CHAR_W-1:CHAR_W];
      default: cur_char = item_q.suffix[CHAR_W-1:0];
    endcase
  end

  // Next prefix: the last used position counts fastest, wrapping 126 to 32.
  always_comb begin
    adv       = prefix_q;
    adv_carry = 1'b1;
    for (int p = MAX_PREFIX - 1; p >= 0; p--) begin
      if (adv_carry && (p < int'(len_q))) begin
        if (prefix_q[p] != CHAR_LAST) begin
          adv[p]    = prefix_q[p] + 1'b1;
          adv_carry = 1'b0;
        end else begin
          adv[p] = CHAR_LO;
        end
      end
    end
  end

  // Tested prefix text, unused positions zero.
  always_comb begin
    ptext = '0;
    for (int k = 0; k < MAX_PREFIX; k++) begin
      if (k < int'(len_q)) begin
        ptext[CHAR_W*k +: CHAR_W] = prefix_q[k];
      end
    end
  end

  assign slot_full = HASH_W'(h_q[SLOT_W-1:0]);
  assign slot16    = slot_full[SLOTOUT_W-1:0];
  assign hit       = rd_q.valid && (rd_q.hash == h_q);

  // Result assembly for the request that is finishing.
  always_comb begin
    res = '0;
    unique case (item_q.kind)
      CMD_LOAD: begin
        res.status      = ST_LOADED;
        res.suffix_text = item_q.suffix;
        res.work_hash   = h_q;
        res.table_slot  = slot16;
      end
      CMD_TEST: begin
        if (skip_q) begin
          res.status = skip_st_q;
        end else begin
          res.status      = hit ? ST_MATCH : ST_NO_MATCH;
          res.prefix_text = ptext;
          res.suffix_text = hit ? rd_q.suffix : '0;
          res.work_hash   = h_q;
          res.table_slot  = slot16;
        end
      end
      CMD_RESTART: begin
        res.status = ST_LOADED;
      end
      default: begin
        res.status = ST_LOADED;
      end
    endcase
  end

  // Sequencer: next state and control.
  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    item_d      = item_q;
    skip_d      = skip_q;
    skip_st_d   = skip_st_q;
    h_d         = h_q;
    prod_d      = prod_q;
    ch_idx_d    = ch_idx_q;
    rem_d       = rem_q;
    len_d       = len_q;
    work_d      = work_q;
    prefix_d    = prefix_q;
    matches_d   = matches_q;
    exhausted_d = exhausted_q;
    pop         = 1'b0;
    emit        = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = h_q[SLOT_W-1:0];
    mem_wdata.valid  = 1'b1;
    mem_wdata.suffix = item_q.suffix;
    mem_wdata.hash   = h_q;

    unique case (state_q)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_idx_q;
        mem_wdata = '0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (&clr_idx_q) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head_i.valid) begin
          pop       = 1'b1;
          item_d    = head_i.item;
          skip_d    = 1'b0;
          skip_st_d = ST_LOADED;
          unique case (head_i.item.kind)
            CMD_LOAD: begin
              h_d      = cfg_i.target_hash;
              ch_idx_d = 2'd2;
              state_d  = BK_UNXOR;
            end
            CMD_TEST: begin
              if (matches_q >= cfg_i.match_limit) begin
                skip_d    = 1'b1;
                skip_st_d = ST_LIMIT;
                state_d   = BK_DONE;
              end else if (exhausted_q) begin
                skip_d    = 1'b1;
                skip_st_d = ST_EXHAUSTED;
                state_d   = BK_DONE;
              end else begin
                h_d     = '0;
                work_d  = PREFIX_W'(prefix_q);
                rem_d   = used_len;
                len_d   = used_len;
                state_d = BK_HASH;
              end
            end
            default: begin
              state_d = BK_DONE;
            end
          endcase
        end
      end
      BK_UNXOR: begin
        prod_d  = unxor(h_q) * INV_1025;
        state_d = BK_UNSUB;
      end
      BK_UNSUB: begin
        h_d = prod_q - HASH_W'(cur_char);
        if (ch_idx_q == 2'd0) begin
          state_d = BK_DONE;
        end else begin
          ch_idx_d = ch_idx_q - 2'd1;
          state_d  = BK_UNXOR;
        end
      end
      BK_HASH: begin
        h_d    = hash_step(h_q, work_q[CHAR_W-1:0]);
        work_d = work_q >> CHAR_W;
        if (rem_q == PLEN_W'(1)) begin
          state_d = BK_READ;
        end else begin
          rem_d = rem_q - 1'b1;
        end
      end
      BK_READ: begin
        state_d = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
          unique case (item_q.kind)
            CMD_LOAD: begin
              mem_we = 1'b1;
            end
            CMD_TEST: begin
              if (!skip_q) begin
                if (hit) begin
                  matches_d = matches_q + 1'b1;
                end
                prefix_d = adv;
                if (adv_carry) begin
                  exhausted_d = 1'b1;
                end
              end
            end
            CMD_RESTART: begin
              prefix_d    = {MAX_PREFIX{CHAR_LO}};
              matches_d   = '0;
              exhausted_d = 1'b0;
            end
            default: begin
              prefix_d    = {MAX_PREFIX{CHAR_LO}};
              matches_d   = '0;
              exhausted_d = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Control and search state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_idx_q   <= '0;
      prefix_q    <= {MAX_PREFIX{CHAR_LO}};
      matches_q   <= '0;
      exhausted_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      prefix_q    <= prefix_d;
      matches_q   <= matches_d;
      exhausted_q <= exhausted_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    skip_q    <= skip_d;
    skip_st_q <= skip_st_d;
    h_q       <= h_d;
    prod_q    <= prod_d;
    ch_idx_q  <= ch_idx_d;
    rem_q     <= rem_d;
    len_q     <= len_d;
    work_q    <= work_d;
    if (emit) begin
      out_q <= res;
    end
  end

  // Hash table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (state_q == BK_READ) begin
      rd_q <= mem[h_q[SLOT_W-1:0]];
    end
  end

  assign status_o.pop      = pop;
  assign status_o.clearing = (state_q == BK_CLEAR);
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_clear_quiet, state_q == BK_CLEAR, !out_valid_q)
  `ASSERT_IMPLIES(a_pop_idle, pop, (state_q == BK_IDLE) && head_i.valid)
  `ASSERT_NEXT(a_match_count, emit && (res.status == ST_MATCH), matches_q == $past(matches_q) + 1'b1)

endmodule

// ----- design/hash_collision_search.sv -----
// Top level of the meet-in-the-middle collision search block.
//
// Requests enter on in_valid_i/in_stall_o with in_data_i; a request is taken
// at a clock edge with in_valid_i high and in_stall_o low. Each request gives
// exactly one result on out_valid_o/out_stall_i with out_data_o, in order.
// A load unwinds target_hash through three suffix characters and stores the
// entry in the table; a test hashes the current prefix, looks it up, reports
// and advances, unless the match limit is reached or the prefixes are
// exhausted, when it only reports; a restart rewinds the prefix and clears
// the match count and the exhausted flag.
// The back end runs one request at a time: a load undoes each suffix
// character with an unxor-and-multiply step and then a subtract step, a test
// takes one hash step per prefix character and then a table read. A two-entry
// queue keeps taking requests, until it is full, while the back end works or
// the output is stalled. After reset the table is swept clear entry by entry,
// during which in_stall_o stays high; configuration writes are taken at any
// time but are meant for when the block is idle. A stalled result holds in
// the output register and the back end waits until it is taken.
module hash_collision_search #(
  parameter int TABLE_DEPTH = 65536,
  parameter int MAX_PREFIX  = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  hcs_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output hcs_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [hcs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hcs_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import hcs_pkg::*;

  cfg_t         cfg_q, cfg_d;
  head_t        head;
  back_status_t back_status;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET_HASH:   cfg_d.target_hash   = cfg_data_i[HASH_W-1:0];
        CFG_PREFIX_LENGTH: cfg_d.prefix_length = cfg_data_i[PLEN_W-1:0];
        CFG_MATCH_LIMIT:   cfg_d.match_limit   = cfg_data_i[LIMIT_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_hash   <= '0;
      cfg_q.prefix_length <= PLEN_RESET;
      cfg_q.match_limit   <= LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: classification and request queue.
  hcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .status_i   (back_status),
    .head_o     (head)
  );

  // Back end: table, hashing and result register.
  hcs_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_PREFIX  (MAX_PREFIX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .status_o    (back_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
